[rtl/vsmau_pkg.sv]
`timescale 1ns / 1ps

package vsmau_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_MEM_RD = 2'd2,
    REQ_MEM_WR = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    FLT_OK        = 2'd0,
    FLT_OVERFLOW  = 2'd1,
    FLT_UNDERFLOW = 2'd2,
    FLT_BAD_ADDR  = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    CFG_SAFE_MODE  = 2'd0,
    CFG_STACK_SIZE = 2'd1,
    CFG_MEM_SIZE   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_e;

  localparam int unsigned SP_W = 12;
  localparam int unsigned SIZE_W = 13;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  size_code;
    logic [11:0] address;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  fault;
    logic [11:0] stack_level;
  } rsp_t;

endpackage

[rtl/vm_stack_and_memory_access_unit.sv]
`timescale 1ns / 1ps

// Datapath: an accepted item reads the banks into the bank read registers beside stage 1;
// stage 1 then passes the result to the output register, and holds while the output stalls.
// Throughput: one item per cycle while the output side is ready; eight byte-lane banks
// per memory serve any 1/2/4/8-byte access with one row access per bank.
// Reset: control and configuration registers go to their defaults, then a clearing pass
// zeroes both memories, during which no item is accepted.
module vm_stack_and_memory_access_unit #(
  parameter int unsigned STACK_BYTES = 4096,
  parameter int unsigned MEM_BYTES   = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  vsmau_pkg::req_t        in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output vsmau_pkg::rsp_t        out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [12:0]            cfg_data_i
);

  localparam int unsigned SAW = $clog2(STACK_BYTES);
  localparam int unsigned MAW = $clog2(MEM_BYTES);
  localparam int unsigned SRW = SAW - 3;
  localparam int unsigned MRW = MAW - 3;
  localparam int unsigned SROWS = STACK_BYTES / 8;
  localparam int unsigned MROWS = MEM_BYTES / 8;
  localparam int unsigned CROWS = (SROWS > MROWS) ? SROWS : MROWS;
  localparam int unsigned CRW = $clog2(CROWS);

  typedef struct packed {
    logic        is_read;
    logic        is_stack;
    logic [2:0]  lo;
    logic [3:0]  nbytes;
    logic [1:0]  fault;
    logic [11:0] sp;
  } s1_t;

  // configuration
  logic        safe_q;
  logic [12:0] stack_size_q;
  logic [12:0] mem_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q       <= 1'b1;
      stack_size_q <= 13'd32;
      mem_size_q   <= 13'd32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vsmau_pkg::CFG_SAFE_MODE:  safe_q       <= cfg_data_i[0];
        vsmau_pkg::CFG_STACK_SIZE: stack_size_q <= cfg_data_i;
        vsmau_pkg::CFG_MEM_SIZE:   mem_size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic [CRW-1:0] clr_cnt_q;
  logic           clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CRW'(CROWS - 1)) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  logic clr_stk, clr_mem;
  assign clr_stk = !clr_done_q && ({1'b0, clr_cnt_q} < (CRW + 1)'(SROWS));
  assign clr_mem = !clr_done_q && ({1'b0, clr_cnt_q} < (CRW + 1)'(MROWS));

  // pipeline control
  logic [11:0] sp_r_q;
  logic   s1_valid_q;
  s1_t    s1_q;
  logic   out_valid_q;
  vsmau_pkg::rsp_t out_q;
  logic   s1_adv;
  logic   accept;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = clr_done_q && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  // request decode and checks
  logic [3:0]  nbytes;
  logic        is_push, is_pop, is_mrd, is_mwr;
  logic [1:0]  fault_d;
  logic [11:0] sp_d;
  logic [11:0] stk_start;
  logic [13:0] push_end;
  logic [13:0] mem_end;
  logic [11:0] pop_base;

  always_comb begin
    nbytes   = 4'd1 << in_i.size_code;
    is_push  = in_i.req_type == vsmau_pkg::REQ_PUSH;
    is_pop   = in_i.req_type == vsmau_pkg::REQ_POP;
    is_mrd   = in_i.req_type == vsmau_pkg::REQ_MEM_RD;
    is_mwr   = in_i.req_type == vsmau_pkg::REQ_MEM_WR;
    push_end = {2'b00, sp_r_q} + {10'd0, nbytes};
    mem_end  = {2'b00, in_i.address} + {10'd0, nbytes};
    pop_base = sp_r_q - {8'd0, nbytes};
    fault_d  = vsmau_pkg::FLT_OK;
    if (safe_q) begin
      if (is_push && (push_end >= {1'b0, stack_size_q})) begin
        fault_d = vsmau_pkg::FLT_OVERFLOW;
      end else if (is_pop && ((sp_r_q < {8'd0, nbytes}) ||
                              ({1'b0, pop_base} >= stack_size_q))) begin
        fault_d = vsmau_pkg::FLT_UNDERFLOW;
      end else if ((is_mrd || is_mwr) && (mem_end > {1'b0, mem_size_q})) begin
        fault_d = vsmau_pkg::FLT_BAD_ADDR;
      end
    end
    sp_d = sp_r_q;
    if (fault_d == vsmau_pkg::FLT_OK) begin
      if (is_push) begin
        sp_d = push_end[11:0];
      end else if (is_pop) begin
        sp_d = pop_base;
      end
    end
    stk_start = is_push ? sp_r_q + 12'd1 : pop_base + 12'd1;
  end

  // per-lane addressing
  logic [7:0]     stk_on, mem_on;
  logic [SRW-1:0] stk_row [8];
  logic [MRW-1:0] mem_row [8];
  logic [7:0]     lane_byte [8];
  logic [7:0]     stk_we, mem_we;
  logic [SRW-1:0] stk_waddr [8];
  logic [MRW-1:0] mem_waddr [8];
  logic [7:0]     stk_wdata [8];
  logic [7:0]     mem_wdata [8];
  logic           stk_re, mem_re;

  always_comb begin
    logic [2:0]  k;
    logic [2:0]  km;
    logic [11:0] spos;
    logic [16:0] spos_w;
    logic [16:0] mpos_w;
    logic [63:0] sh;
    for (int b = 0; b < 8; b++) begin
      k      = 3'(b) - stk_start[2:0];
      km     = 3'(b) - in_i.address[2:0];
      spos   = stk_start + {9'd0, k};
      spos_w = {5'd0, spos};
      mpos_w = {5'd0, in_i.address} + {14'd0, km};
      stk_row[b] = spos_w[SAW-1:3];
      mem_row[b] = mpos_w[MAW-1:3];
      stk_on[b]  = {1'b0, k} < nbytes;
      mem_on[b]  = {1'b0, km} < nbytes;
      sh = in_i.value >> {(is_push ? k : km), 3'b000};
      lane_byte[b] = sh[7:0];
    end
  end

  always_comb begin
    logic ok;
    ok     = accept && (fault_d == vsmau_pkg::FLT_OK);
    stk_re = ok && is_pop;
    mem_re = ok && is_mrd;
    for (int b = 0; b < 8; b++) begin
      if (clr_stk) begin
        stk_we[b]    = 1'b1;
        stk_waddr[b] = clr_cnt_q[SRW-1:0];
        stk_wdata[b] = 8'd0;
      end else begin
        stk_we[b]    = ok && is_push && stk_on[b];
        stk_waddr[b] = stk_row[b];
        stk_wdata[b] = lane_byte[b];
      end
      if (clr_mem) begin
        mem_we[b]    = 1'b1;
        mem_waddr[b] = clr_cnt_q[MRW-1:0];
        mem_wdata[b] = 8'd0;
      end else begin
        mem_we[b]    = ok && is_mwr && mem_on[b];
        mem_waddr[b] = mem_row[b];
        mem_wdata[b] = lane_byte[b];
      end
    end
  end

  // byte-lane banks
  logic [7:0] stk_mem [8][SROWS];
  logic [7:0] mem_mem [8][MROWS];
  logic [7:0] stk_rd_q [8];
  logic [7:0] mem_rd_q [8];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 8; b++) begin
      if (stk_we[b]) begin
        stk_mem[b][stk_waddr[b]] <= stk_wdata[b];
      end
      if (stk_re) begin
        stk_rd_q[b] <= stk_mem[b][stk_row[b]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 8; b++) begin
      if (mem_we[b]) begin
        mem_mem[b][mem_waddr[b]] <= mem_wdata[b];
      end
      if (mem_re) begin
        mem_rd_q[b] <= mem_mem[b][mem_row[b]];
      end
    end
  end

  // stack pointer and stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_r_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        sp_r_q     <= sp_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.is_read  <= (fault_d == vsmau_pkg::FLT_OK) && (is_pop || is_mrd);
      s1_q.is_stack <= is_pop;
      s1_q.lo       <= is_pop ? stk_start[2:0] : in_i.address[2:0];
      s1_q.nbytes   <= nbytes;
      s1_q.fault    <= fault_d;
      s1_q.sp       <= sp_d;
    end
  end

  // result assembly
  logic [63:0] rdata;

  always_comb begin
    logic [2:0] lane;
    logic [7:0] byte_v;
    rdata = '0;
    for (int j = 0; j < 8; j++) begin
      lane   = s1_q.lo + 3'(j);
      byte_v = s1_q.is_stack ? stk_rd_q[lane] : mem_rd_q[lane];
      if (s1_q.is_read && (4'(j) < s1_q.nbytes)) begin
        rdata[8*j +: 8] = byte_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q.read_data   <= rdata;
      out_q.fault       <= s1_q.fault;
      out_q.stack_level <= s1_q.sp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> clr_done_q)
    else $error("item accepted during clearing pass");

  a_fault_keeps_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (fault_d != vsmau_pkg::FLT_OK)) |=> sp_r_q == $past(sp_r_q))
    else $error("faulting item changed the stack pointer");

  a_push_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && safe_q && is_push && (fault_d == vsmau_pkg::FLT_OK))
    |=> {1'b0, sp_r_q} < stack_size_q)
    else $error("safe push left stack pointer out of range");

  a_fault_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.fault != vsmau_pkg::FLT_OK)) |-> out_q.read_data == 64'd0)
    else $error("faulting result carries data");

  a_s1_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q && $stable(s1_q))
    else $error("stalled stage 1 item dropped or changed");

endmodule
